@@ hdl/joystick_frame_parser_assert.svh @@
// ----------------------------------------------------------------------------
// joystick_frame_parser_assert.svh
// assertion macros for the frame parser checker
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_FRAME_PARSER_ASSERT_SVH
`define JOYSTICK_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define JFP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define JFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/jfp_pkg.sv @@
// ----------------------------------------------------------------------------
// jfp_pkg
// shared types and character codes for the joystick frame parser
// ----------------------------------------------------------------------------
package jfp_pkg;

    // frame characters
    localparam logic [7:0] CHAR_START = 8'h53;  // 'S'
    localparam logic [7:0] CHAR_END   = 8'h45;  // 'E'
    localparam logic [7:0] CHAR_COMMA = 8'h2C;  // ','
    localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    // magnitude saturation point
    localparam int unsigned MAG_W     = 16;
    localparam logic [MAG_W-1:0] MAG_LIMIT = 16'd32768;

    // one decoded frame
    typedef struct packed {
        logic               controller_id;
        logic signed [15:0] x_value;
        logic signed [15:0] y_value;
    } result_t;

endpackage

@@ hdl/jfp_core.sv @@
// ----------------------------------------------------------------------------
// jfp_core
// per-byte frame state update and result formatting
// ----------------------------------------------------------------------------
module jfp_core #(
    parameter int BUFFER_BYTES = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    output logic             emit,
    output jfp_pkg::result_t result
);

    localparam int CNT_W = $clog2(BUFFER_BYTES);

    typedef enum logic [1:0] {
        PH_BLANK  = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    logic [CNT_W-1:0]          count_reg,  count_next;
    logic                      open_reg,   open_next;
    logic                      bad_reg,    bad_next;
    logic                      id_reg,     id_next;
    logic                      fsel_reg,   fsel_next;
    phase_t                    phase_reg,  phase_next;
    logic                      neg_reg,    neg_next;
    logic [jfp_pkg::MAG_W-1:0] xmag_reg,   xmag_next;
    logic [jfp_pkg::MAG_W-1:0] ymag_reg,   ymag_next;
    logic                      xneg_reg,   xneg_next;

    logic                      kept;
    logic                      is_digit;
    logic                      is_blank;
    logic [jfp_pkg::MAG_W-1:0] cur_mag;
    logic [18:0]               mag_sum;
    logic [jfp_pkg::MAG_W-1:0] mag_acc;
    logic [jfp_pkg::MAG_W-1:0] fed_mag;
    phase_t                    fed_phase;
    logic                      fed_neg;

    // signed 16-bit view of a saturated magnitude
    function automatic logic [15:0] to_signed16(input logic [jfp_pkg::MAG_W-1:0] mag,
                                                input logic neg);
        logic [15:0] val;
        begin
            if (neg)
            begin
                val = 16'(~mag + 16'd1);
            end
            else if (mag > 16'd32767)
            begin
                val = 16'd32767;
            end
            else
            begin
                val = mag;
            end
            return val;
        end
    endfunction

    // character classes
    assign is_digit = (rx_byte >= jfp_pkg::CHAR_ZERO) && (rx_byte <= jfp_pkg::CHAR_NINE);
    assign is_blank = (rx_byte == jfp_pkg::CHAR_SPACE) ||
                      ((rx_byte >= jfp_pkg::CHAR_TAB) && (rx_byte <= jfp_pkg::CHAR_CR));
    assign kept     = count_reg < CNT_W'(BUFFER_BYTES - 1);

    // decimal accumulate, times ten by shifts, saturated
    assign cur_mag = fsel_reg ? ymag_reg : xmag_reg;
    assign mag_sum = (19'(cur_mag) << 3) + (19'(cur_mag) << 1)
                   + 19'(rx_byte - jfp_pkg::CHAR_ZERO);
    assign mag_acc = (mag_sum > 19'(jfp_pkg::MAG_LIMIT)) ? jfp_pkg::MAG_LIMIT
                                                          : mag_sum[15:0];

    // number field parsing for the selected field
    always_comb
    begin
        fed_mag   = cur_mag;
        fed_phase = phase_reg;
        fed_neg   = neg_reg;
        unique case (phase_reg)
            PH_BLANK:
            begin
                if (is_blank)
                begin
                    fed_phase = PH_BLANK;
                end
                else if (rx_byte == jfp_pkg::CHAR_PLUS)
                begin
                    fed_phase = PH_DIGITS;
                end
                else if (rx_byte == jfp_pkg::CHAR_MINUS)
                begin
                    fed_neg   = 1'b1;
                    fed_phase = PH_DIGITS;
                end
                else if (is_digit)
                begin
                    fed_mag   = mag_acc;
                    fed_phase = PH_DIGITS;
                end
                else
                begin
                    fed_phase = PH_DONE;
                end
            end
            PH_DIGITS:
            begin
                if (is_digit)
                begin
                    fed_mag = mag_acc;
                end
                else
                begin
                    fed_phase = PH_DONE;
                end
            end
            default:
            begin
                fed_phase = phase_reg;
            end
        endcase
    end

    // result fields from the current frame state
    always_comb
    begin
        result.controller_id = id_reg;
        result.x_value       = to_signed16(xmag_reg, fsel_reg ? xneg_reg : neg_reg);
        result.y_value       = fsel_reg ? to_signed16(ymag_reg, neg_reg) : 16'sd0;
    end

    // frame state update for one item
    always_comb
    begin
        count_next = count_reg;
        open_next  = open_reg;
        bad_next   = bad_reg;
        id_next    = id_reg;
        fsel_next  = fsel_reg;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        xmag_next  = xmag_reg;
        ymag_next  = ymag_reg;
        xneg_next  = xneg_reg;
        emit       = 1'b0;

        if (step)
        begin
            if (rx_byte == jfp_pkg::CHAR_START)
            begin
                count_next = CNT_W'(1);
                open_next  = 1'b1;
                bad_next   = 1'b0;
                id_next    = 1'b1;
                fsel_next  = 1'b0;
                phase_next = PH_BLANK;
                neg_next   = 1'b0;
                xmag_next  = '0;
                ymag_next  = '0;
                xneg_next  = 1'b0;
            end
            else if (open_reg)
            begin
                if (kept)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    bad_next = 1'b1;
                end
                if (rx_byte == jfp_pkg::CHAR_NUL)
                begin
                    bad_next = 1'b1;
                end

                if (rx_byte == jfp_pkg::CHAR_END)
                begin
                    // close the frame, report it if good
                    emit       = !bad_next;
                    count_next = '0;
                    open_next  = 1'b0;
                    bad_next   = 1'b0;
                    id_next    = 1'b1;
                    fsel_next  = 1'b0;
                    phase_next = PH_BLANK;
                    neg_next   = 1'b0;
                    xmag_next  = '0;
                    ymag_next  = '0;
                    xneg_next  = 1'b0;
                end
                else if (!bad_next)
                begin
                    if (count_reg == CNT_W'(1))
                    begin
                        id_next = (rx_byte != jfp_pkg::CHAR_ZERO);
                    end
                    else if (count_reg >= CNT_W'(3))
                    begin
                        if (!fsel_reg && (rx_byte == jfp_pkg::CHAR_COMMA))
                        begin
                            xneg_next  = neg_reg;
                            fsel_next  = 1'b1;
                            phase_next = PH_BLANK;
                            neg_next   = 1'b0;
                        end
                        else
                        begin
                            phase_next = fed_phase;
                            neg_next   = fed_neg;
                            if (fsel_reg)
                            begin
                                ymag_next = fed_mag;
                            end
                            else
                            begin
                                xmag_next = fed_mag;
                            end
                        end
                    end
                end
            end
        end
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            open_reg  <= 1'b0;
            bad_reg   <= 1'b0;
            id_reg    <= 1'b1;
            fsel_reg  <= 1'b0;
            phase_reg <= PH_BLANK;
            neg_reg   <= 1'b0;
            xmag_reg  <= '0;
            ymag_reg  <= '0;
            xneg_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            open_reg  <= open_next;
            bad_reg   <= bad_next;
            id_reg    <= id_next;
            fsel_reg  <= fsel_next;
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            xmag_reg  <= xmag_next;
            ymag_reg  <= ymag_next;
            xneg_reg  <= xneg_next;
        end
    end

endmodule

@@ hdl/joystick_frame_parser.sv @@
// ----------------------------------------------------------------------------
// joystick_frame_parser
// parses serial bytes into joystick frames: S, id, separator, x, comma, y, E
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  input     in         in_valid / in_ready    rx_byte
//  output    out        out_valid / out_ready  controller_id, x_value, y_value
//
//  one byte per cycle while in_ready is high; a byte goes through an input
//  register, then the frame state update, and a finished frame is loaded into
//  the output register when its E byte moves on from the input register
//  reset clears the frame state and the valid flags of both registers
//  a stalled output holds its item; in_ready drops only while both registers
//  hold an item and out_ready is low
// ----------------------------------------------------------------------------
module joystick_frame_parser #(
    parameter int BUFFER_BYTES = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               controller_id,
    output logic signed [15:0] x_value,
    output logic signed [15:0] y_value
);

    logic             in_valid_reg;
    logic [7:0]       byte_reg;
    logic             out_valid_reg;
    jfp_pkg::result_t result_reg;
    jfp_pkg::result_t core_result;
    logic             advance;
    logic             step;
    logic             emit;

    // the input register moves on when the output register is free
    assign advance  = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    jfp_core #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (byte_reg),
        .emit    (emit),
        .result  (core_result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            result_reg <= core_result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign controller_id = result_reg.controller_id;
    assign x_value       = result_reg.x_value;
    assign y_value       = result_reg.y_value;

endmodule

@@ hdl/jfp_checker.sv @@
// ----------------------------------------------------------------------------
// jfp_checker
// port-level checks for the joystick frame parser, bound to the top level
// ----------------------------------------------------------------------------
`include "joystick_frame_parser_assert.svh"

module jfp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               controller_id,
    input logic signed [15:0] x_value,
    input logic signed [15:0] y_value
);

    // a waiting item stays offered
    `JFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // a waiting item keeps its fields
    `JFP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable({controller_id, x_value, y_value}))

    // an empty output side never blocks the input
    `JFP_ASSERT_NOW(a_in_free, !out_valid, in_ready)

    // a new item only follows an earlier accepted byte
    `JFP_ASSERT_NOW(a_out_cause, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind joystick_frame_parser jfp_checker u_jfp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .controller_id (controller_id),
    .x_value       (x_value),
    .y_value       (y_value)
);

@@ tb/sv/joystick_frame_parser_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_frame_parser_tb
// self-checking bench for the joystick frame parser: bytes go in through a
// valid/ready driver with random gaps, a frame decoder in the bench predicts
// every finished frame, and each output item is checked field by field
// ----------------------------------------------------------------------------
module joystick_frame_parser_tb;

    localparam int BUFFER_BYTES = 128;
    localparam int ITEM_TARGET  = 1900;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 10;

    typedef enum logic [1:0] {SKIP_BLANK, READ_DIGITS, NUMBER_DONE} phase_t;
    typedef enum logic {FIELD_X, FIELD_Y} field_t;

    // frame decoder and store of expected frames
    class frame_tracker;
        jfp_pkg::result_t expected_frames[$];
        int unsigned      errors;
        int unsigned      kept_count;
        bit               in_frame;
        bit               reject;
        logic             id_flag;
        field_t           field;
        phase_t           phase;
        logic             negative;
        logic             x_neg;
        logic [15:0]      x_mag;
        logic [15:0]      y_mag;

        function new();
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            kept_count = 0;
            in_frame   = 0;
            reject     = 0;
            id_flag    = 1'b1;
            field      = FIELD_X;
            phase      = SKIP_BLANK;
            negative   = 1'b0;
            x_neg      = 1'b0;
            x_mag      = '0;
            y_mag      = '0;
        endfunction

        // decimal accumulate, saturating at the magnitude limit
        function logic [15:0] add_digit(logic [15:0] mag, logic [7:0] b);
            int m;
            m = int'(mag) * 10 + int'(b) - int'(jfp_pkg::CHAR_ZERO);
            if (m > int'(jfp_pkg::MAG_LIMIT))
            begin
                m = int'(jfp_pkg::MAG_LIMIT);
            end
            return 16'(m);
        endfunction

        // atoi style: blanks, optional sign, then digits
        function logic [15:0] feed_number(logic [15:0] mag, logic [7:0] b);
            bit digit;
            bit blank;
            digit = (b >= jfp_pkg::CHAR_ZERO && b <= jfp_pkg::CHAR_NINE);
            blank = (b == jfp_pkg::CHAR_SPACE)
                    || (b >= jfp_pkg::CHAR_TAB && b <= jfp_pkg::CHAR_CR);
            case (phase)
                SKIP_BLANK:
                begin
                    if (blank)
                    begin
                        phase = SKIP_BLANK;
                    end
                    else if (b == jfp_pkg::CHAR_PLUS)
                    begin
                        phase = READ_DIGITS;
                    end
                    else if (b == jfp_pkg::CHAR_MINUS)
                    begin
                        negative = 1'b1;
                        phase    = READ_DIGITS;
                    end
                    else if (digit)
                    begin
                        mag   = add_digit(mag, b);
                        phase = READ_DIGITS;
                    end
                    else
                    begin
                        phase = NUMBER_DONE;
                    end
                end
                READ_DIGITS:
                begin
                    if (digit)
                    begin
                        mag = add_digit(mag, b);
                    end
                    else
                    begin
                        phase = NUMBER_DONE;
                    end
                end
                default:
                begin
                    phase = NUMBER_DONE;
                end
            endcase
            return mag;
        endfunction

        // magnitude and sign to a clamped 16-bit value
        function logic signed [15:0] as_value(logic [15:0] mag, logic neg);
            int v;
            v = int'(mag);
            if (neg)
            begin
                if (v > int'(jfp_pkg::MAG_LIMIT))
                begin
                    v = int'(jfp_pkg::MAG_LIMIT);
                end
                return 16'(-v);
            end
            if (v > int'(jfp_pkg::MAG_LIMIT) - 1)
            begin
                v = int'(jfp_pkg::MAG_LIMIT) - 1;
            end
            return 16'(v);
        endfunction

        // one accepted byte; returns 1 when the parser had to act on it
        function bit take_byte(logic [7:0] b);
            int unsigned      idx;
            bit               kept;
            jfp_pkg::result_t frame;
            if (b == jfp_pkg::CHAR_START)
            begin
                clear_frame();
                in_frame   = 1;
                kept_count = 1;
                return 1;
            end
            if (!in_frame)
            begin
                return 0;
            end

            // store bookkeeping
            idx  = kept_count;
            kept = idx < BUFFER_BYTES - 1;
            if (kept)
            begin
                kept_count = idx + 1;
            end
            else
            begin
                reject = 1;
            end
            if (b == jfp_pkg::CHAR_NUL)
            begin
                reject = 1;
            end

            // end of frame
            if (b == jfp_pkg::CHAR_END)
            begin
                if (!reject)
                begin
                    frame.controller_id = id_flag;
                    frame.x_value = as_value(x_mag, (field == FIELD_Y) ? x_neg : negative);
                    frame.y_value = (field == FIELD_Y) ? as_value(y_mag, negative) : '0;
                    expected_frames.push_back(frame);
                end
                clear_frame();
                return 1;
            end
            if (reject || !kept)
            begin
                return 1;
            end

            // id byte, then the x and y fields
            if (idx == 1)
            begin
                id_flag = (b != jfp_pkg::CHAR_ZERO);
            end
            else if (idx >= 3)
            begin
                if (field == FIELD_X && b == jfp_pkg::CHAR_COMMA)
                begin
                    x_neg    = negative;
                    field    = FIELD_Y;
                    phase    = SKIP_BLANK;
                    negative = 1'b0;
                end
                else if (field == FIELD_X)
                begin
                    x_mag = feed_number(x_mag, b);
                end
                else
                begin
                    y_mag = feed_number(y_mag, b);
                end
            end
            return 1;
        endfunction

        // compare one output item with the oldest expected frame
        function void check_frame(logic id, logic signed [15:0] x, logic signed [15:0] y);
            jfp_pkg::result_t want;
            if (expected_frames.size() == 0)
            begin
                $error("frame out with none expected: id %0d x %0d y %0d", id, x, y);
                errors++;
                return;
            end
            want = expected_frames.pop_front();
            if (want.controller_id !== id)
            begin
                $error("controller_id mismatch: expected %0d, got %0d", want.controller_id, id);
                errors++;
            end
            if (want.x_value !== x)
            begin
                $error("x_value mismatch: expected %0d, got %0d", want.x_value, x);
                errors++;
            end
            if (want.y_value !== y)
            begin
                $error("y_value mismatch: expected %0d, got %0d", want.y_value, y);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         rx_byte;
    logic               out_valid;
    logic               out_ready;
    logic               controller_id;
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;

    frame_tracker tracker = new();
    logic [7:0]   byte_queue[$];
    int           bytes_used;
    int           cycle_count;
    bit           idle_bursts;

    joystick_frame_parser #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .controller_id (controller_id),
        .x_value       (x_value),
        .y_value       (y_value)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // watch both handshakes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                if (tracker.take_byte(rx_byte))
                begin
                    bytes_used++;
                end
            end
            if (out_valid && out_ready)
            begin
                tracker.check_frame(controller_id, x_value, y_value);
            end
        end
    end

    // output side stalls in bursts
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_bursts && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // timeout
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("joystick_frame_parser test failed");
        $finish;
    end

    // one item on the input channel, with an optional gap first
    task automatic send_byte(input logic [7:0] b);
        if (idle_bursts && $urandom_range(0, 6) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_queued();
        while (byte_queue.size() != 0)
        begin
            send_byte(byte_queue.pop_front());
        end
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            byte_queue.push_back(s[i]);
        end
    endtask

    // random number text: blanks, sign, digits, sometimes a trailing junk byte
    task automatic append_number();
        int digits;
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                byte_queue.push_back(($urandom_range(0, 5) == 5) ? jfp_pkg::CHAR_SPACE
                                     : jfp_pkg::CHAR_TAB + 8'($urandom_range(0, 4)));
            end
        end
        case ($urandom_range(0, 5))
            0: byte_queue.push_back(jfp_pkg::CHAR_PLUS);
            1, 2: byte_queue.push_back(jfp_pkg::CHAR_MINUS);
            default: ;
        endcase
        digits = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 8) : $urandom_range(0, 5);
        repeat (digits)
        begin
            byte_queue.push_back(jfp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 7) == 0)
        begin
            byte_queue.push_back(8'($urandom_range(8'h21, 8'h7E)));
        end
    endtask

    // S, id, separator, x, comma, y and optionally E
    task automatic append_frame(input bit with_end);
        byte_queue.push_back(jfp_pkg::CHAR_START);
        case ($urandom_range(0, 4))
            0, 1: byte_queue.push_back(jfp_pkg::CHAR_ZERO);
            2, 3: byte_queue.push_back(jfp_pkg::CHAR_ZERO + 8'd1);
            default: byte_queue.push_back(8'($urandom_range(8'h21, 8'h7E)));
        endcase
        byte_queue.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'h21, 8'h7E))
                             : 8'h3A);
        append_number();
        byte_queue.push_back(jfp_pkg::CHAR_COMMA);
        append_number();
        if (with_end)
        begin
            byte_queue.push_back(jfp_pkg::CHAR_END);
        end
    endtask

    // mostly well-formed frames, the rest broken frames and line noise
    task automatic append_random_frame();
        int kind;
        int start;
        int len;
        kind  = $urandom_range(0, 99);
        start = byte_queue.size();
        if (kind < 70)
        begin
            append_frame(1);
        end
        else if (kind < 76)
        begin
            // zero byte somewhere inside
            append_frame(1);
            byte_queue[$urandom_range(start + 1, byte_queue.size() - 2)] = jfp_pkg::CHAR_NUL;
        end
        else if (kind < 81)
        begin
            // no end, the next S restarts
            append_frame(0);
        end
        else if (kind < 88)
        begin
            // short frame: up to three random bytes between S and E
            byte_queue.push_back(jfp_pkg::CHAR_START);
            repeat ($urandom_range(0, 3))
            begin
                byte_queue.push_back(8'($urandom_range(0, 255)));
            end
            byte_queue.push_back(jfp_pkg::CHAR_END);
        end
        else if (kind < 94)
        begin
            repeat ($urandom_range(1, 6))
            begin
                byte_queue.push_back(8'($urandom_range(0, 255)));
            end
        end
        else if (kind < 97)
        begin
            byte_queue.push_back(jfp_pkg::CHAR_START);
            repeat ($urandom_range(1, 12))
            begin
                byte_queue.push_back(8'($urandom_range(0, 255)));
            end
            byte_queue.push_back(jfp_pkg::CHAR_END);
        end
        else
        begin
            // long frame around the store limit
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(132, 180)
                  : $urandom_range(BUFFER_BYTES - 4, BUFFER_BYTES + 3);
            push_text("S1:5,");
            while (byte_queue.size() - start < len - 1)
            begin
                byte_queue.push_back(jfp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
            byte_queue.push_back(jfp_pkg::CHAR_END);
        end
    endtask

    // main sequence
    initial
    begin
        bit drained;
        drained     = 0;
        bytes_used  = 0;
        idle_bursts = 1;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        rx_byte    <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: stray bytes, bare frame, id zero, saturation, zero byte
        byte_queue.push_back(8'hFF);
        byte_queue.push_back(jfp_pkg::CHAR_END);
        push_text("SE");
        push_text("S0E");
        push_text("S1:-99999,\t40000E");
        byte_queue.push_back(jfp_pkg::CHAR_START);
        byte_queue.push_back(8'hFF);
        push_text(":7");
        byte_queue.push_back(jfp_pkg::CHAR_NUL);
        byte_queue.push_back(jfp_pkg::CHAR_END);
        send_queued();

        // random frames; a quiet stretch in the middle and at the end
        while (bytes_used < ITEM_TARGET)
        begin
            idle_bursts = !(bytes_used >= 600 && bytes_used < 900)
                          && bytes_used < ITEM_TARGET - 250;
            if (!drained && bytes_used >= 1100)
            begin
                // hold off until every frame has come out
                drained = 1;
                in_valid <= 1'b0;
                @(posedge clk);
                while (tracker.expected_frames.size() != 0)
                begin
                    @(posedge clk);
                end
            end
            append_random_frame();
            send_queued();
        end

        // drain
        in_valid <= 1'b0;
        while (tracker.expected_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.errors == 0 && tracker.expected_frames.size() == 0)
        begin
            $display("joystick_frame_parser test passed");
        end
        else
        begin
            $display("joystick_frame_parser test failed");
        end
        $finish;
    end

endmodule
